// ----- rtl/vtc_pkg.sv -----
// ----------------------------------------------------------------------------
// vtc_pkg
// Constants shared by the value type classifier: result codes and keyword table.
// ----------------------------------------------------------------------------
package vtc_pkg;

	localparam int TYPE_W = 3;

	typedef logic [TYPE_W-1:0] type_code_t;

	localparam type_code_t TC_CHARACTER = 3'd0;
	localparam type_code_t TC_DECIMAL   = 3'd1;
	localparam type_code_t TC_BOOLEAN   = 3'd2;
	localparam type_code_t TC_INTEGER   = 3'd3;
	localparam type_code_t TC_STRING    = 3'd4;

	localparam logic [7:0] DIGIT_LO = 8'h30;
	localparam logic [7:0] DIGIT_HI = 8'h39;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam int KW_COUNT  = 4;
	localparam int KW_MAXLEN = 10;
	localparam int KW_IDX_W  = $clog2(KW_MAXLEN);

	typedef logic [KW_COUNT-1:0] kw_mask_t;
	typedef logic [KW_IDX_W:0]   kw_len_t;

	// true, false, verdadeiro, falso
	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
		'{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h76, 8'h65, 8'h72, 8'h64, 8'h61, 8'h64, 8'h65, 8'h69, 8'h72, 8'h6F},
		'{8'h66, 8'h61, 8'h6C, 8'h73, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam kw_len_t KW_LEN [KW_COUNT] = '{5'd4, 5'd5, 5'd10, 5'd5};

endpackage

// ----- rtl/value_type_classifier_core.sv -----
// ----------------------------------------------------------------------------
// value_type_classifier_core
// Classifies a byte string as character, decimal, boolean, integer or string.
//
// A string enters as one item per byte followed by one terminator item
// (end_of_text high, text_byte ignored); only the terminator produces a
// result. Byte items are taken one per cycle, pausing only while a
// terminator waits at the input register. Each item is registered on entry;
// a byte item then updates the counter and flag registers, and a terminator
// loads the result register from them. The result register frees as it is
// taken, and a terminator waits at the input register only while an earlier
// result is still held by a stalled consumer. Strings longer than MAX_LEN
// bytes report string with length_overflow set. No clearing pass after reset.
// ----------------------------------------------------------------------------
module value_type_classifier_core #(
	parameter int MAX_LEN = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_stall,
	input  logic [7:0]            text_byte,
	input  logic                  end_of_text,
	output logic                  result_valid,
	input  logic                  result_stall,
	output vtc_pkg::type_code_t   type_code,
	output logic                  length_overflow
);
	import vtc_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	typedef logic [CW-1:0] count_t;

	localparam count_t MAX_COUNT = CW'(MAX_LEN);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// string state
	count_t   byte_count_q;
	count_t   digit_count_q;
	count_t   dot_position_q;
	logic     dot_seen_q;
	logic     only_digits_q;
	kw_mask_t keyword_alive_q;
	logic     too_long_q;

	// result register
	logic       out_valid_q;
	type_code_t type_code_q;
	logic       overflow_q;

	logic       out_free;
	logic       advance;
	logic       is_digit;
	logic       is_dot;
	kw_mask_t   alive_next;
	type_code_t class_code;
	logic       kw_hit;

	assign out_free   = !out_valid_q || !result_stall;
	assign advance    = valid_s1 && (!end_s1 || out_free);
	assign text_stall = valid_s1 && !advance;

	assign is_digit = (byte_s1 >= DIGIT_LO) && (byte_s1 <= DIGIT_HI);
	assign is_dot   = (byte_s1 == DOT_CHAR);

	// drop keywords that no longer match at this position
	always_comb begin
		alive_next = keyword_alive_q;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (byte_count_q >= CW'(KW_LEN[k])) begin
				alive_next[k] = 1'b0;
			end else if (KW_TEXT[k][byte_count_q[KW_IDX_W-1:0]] != byte_s1) begin
				alive_next[k] = 1'b0;
			end
		end
	end

	always_comb begin
		kw_hit = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (keyword_alive_q[k] && (byte_count_q == CW'(KW_LEN[k]))) begin
				kw_hit = 1'b1;
			end
		end
	end

	always_comb begin
		if (too_long_q) begin
			class_code = TC_STRING;
		end else if (dot_seen_q && (byte_count_q >= CW'(3))
				&& (digit_count_q == byte_count_q - CW'(1))
				&& (dot_position_q != '0)
				&& (dot_position_q < byte_count_q - CW'(1))) begin
			class_code = TC_DECIMAL;
		end else if (only_digits_q && (byte_count_q != '0)) begin
			class_code = TC_INTEGER;
		end else if (byte_count_q == CW'(1)) begin
			class_code = TC_CHARACTER;
		end else if (kw_hit) begin
			class_code = TC_BOOLEAN;
		end else begin
			class_code = TC_STRING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall) begin
			byte_s1 <= text_byte;
			end_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			digit_count_q   <= '0;
			dot_position_q  <= '0;
			dot_seen_q      <= 1'b0;
			only_digits_q   <= 1'b1;
			keyword_alive_q <= '1;
			too_long_q      <= 1'b0;
		end else if (advance) begin
			if (end_s1) begin
				byte_count_q    <= '0;
				digit_count_q   <= '0;
				dot_position_q  <= '0;
				dot_seen_q      <= 1'b0;
				only_digits_q   <= 1'b1;
				keyword_alive_q <= '1;
				too_long_q      <= 1'b0;
			end else if (!too_long_q) begin
				if (byte_count_q >= MAX_COUNT) begin
					too_long_q <= 1'b1;
				end else begin
					keyword_alive_q <= alive_next;
					if (is_digit) begin
						digit_count_q <= digit_count_q + CW'(1);
					end else begin
						only_digits_q <= 1'b0;
					end
					if (is_dot) begin
						dot_seen_q     <= 1'b1;
						dot_position_q <= byte_count_q;
					end
					byte_count_q <= byte_count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			type_code_q <= class_code;
			overflow_q  <= too_long_q;
		end
	end

	assign result_valid    = out_valid_q;
	assign type_code       = type_code_q;
	assign length_overflow = overflow_q;

`ifndef SYNTH
	a_overflow_is_string: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && overflow_q |-> type_code_q == TC_STRING)
		else $error("overflow result not reported as string");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= MAX_COUNT && digit_count_q <= byte_count_q)
		else $error("byte or digit count out of range");

	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s1 && end_s1 && out_valid_q && result_stall)
		else $error("input stalled without a held result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_s1 |=> out_valid_q)
		else $error("terminator advanced without a result");
`endif

endmodule
